@@ rtl/core/slu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_pkg
// Shared types, codes and address constants of the console serial line unit.
// ----------------------------------------------------------------------------
package slu_pkg;

  // item codes
  localparam logic [2:0] MODE_READ      = 3'd0;
  localparam logic [2:0] MODE_WRITE     = 3'd1;
  localparam logic [2:0] MODE_HOST_CHAR = 3'd2;
  localparam logic [2:0] MODE_RX_ACK    = 3'd3;
  localparam logic [2:0] MODE_TX_ACK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_EIGHT_BIT    = 2'd0;
  localparam logic [1:0] CFG_NL_TO_CR     = 2'd1;
  localparam logic [1:0] CFG_ALIAS_ENABLE = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // bus addresses, octal
  localparam logic [15:0] RANGE_MASK   = 16'o177770;
  localparam logic [15:0] PRIMARY_BASE = 16'o177560;
  localparam logic [15:0] ALIAS_BASE   = 16'o176500;
  localparam logic [15:0] ADDR_RCSR    = 16'o177560;
  localparam logic [15:0] ADDR_RBUF    = 16'o177562;
  localparam logic [15:0] ADDR_TCSR    = 16'o177564;
  localparam logic [15:0] ADDR_TBUF    = 16'o177566;

  // status bits
  localparam int unsigned DONE_POS  = 7;
  localparam int unsigned IE_POS    = 6;
  localparam int unsigned MAINT_POS = 2;
  localparam int unsigned BREAK_POS = 0;
  localparam int unsigned RE_POS    = 0;

  localparam logic [7:0] SEVEN_MASK = 8'o177;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  host_char;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       rx_taken;
    logic       rx_irq;
    logic       tx_irq;
  } rsp_t;

  function automatic logic [7:0] mask_char(input logic [7:0] c, input logic eight_bit);
    mask_char = eight_bit ? c : (c & SEVEN_MASK);
  endfunction

endpackage

@@ rtl/core/serial_line_unit_registers.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_unit_registers
// Console serial line unit: receiver and transmitter status and buffer
// registers, with character receive, immediate transmit and interrupt latches.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  cmd      in   cmd_valid/cmd_stall   slu_pkg::cmd_t (mode, address, data, char)
//  rsp      out  rsp_valid/rsp_stall   slu_pkg::rsp_t (read data, tx, rx_taken, irqs)
//  apb      in   psel/penable/pready   eight-bit, newline, alias controls
//
//  one beat per cycle while rsp_stall is low; a beat passes from cmd to rsp
//  through the input register, then decode and latch update into the result register
//  state latches and the result register move together, so item order is kept
//  rsp_stall holds the result register and the input register behind it
//  rst is synchronous; the controls come back to eight-bit off, newline off,
//  alias on, and the transmitter reports done
// ----------------------------------------------------------------------------
module serial_line_unit_registers (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  slu_pkg::cmd_t                 cmd,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output slu_pkg::rsp_t                 rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slu_pkg::PADDR_W-1:0]   paddr,
  input  logic [slu_pkg::PDATA_W-1:0]   pwdata,
  output logic [slu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // configuration
  logic eight_bit_mode;
  logic newline_to_return;
  logic alias_enable;
  logic cfg_wr;

  // unit state
  logic [7:0] rx_byte,    rx_byte_next;
  logic       rx_done,    rx_done_next;
  logic       rx_enable,  rx_enable_next;
  logic       rx_request, rx_request_next;
  logic       tx_done,    tx_done_next;
  logic       tx_enable,  tx_enable_next;
  logic       tx_request, tx_request_next;
  logic [1:0] maint_break_bits, maint_break_bits_next;

  // pipeline
  logic          s1_valid;
  slu_pkg::cmd_t s1_cmd;
  logic          advance;
  logic          fire;
  slu_pkg::rsp_t rsp_next;
  logic [15:0]   addr;
  logic [7:0]    host_c;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eight_bit_mode    <= 1'b0;
      newline_to_return <= 1'b0;
      alias_enable      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        slu_pkg::CFG_EIGHT_BIT:    eight_bit_mode    <= pwdata[0];
        slu_pkg::CFG_NL_TO_CR:     newline_to_return <= pwdata[0];
        slu_pkg::CFG_ALIAS_ENABLE: alias_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      slu_pkg::CFG_EIGHT_BIT:    prdata[0] = eight_bit_mode;
      slu_pkg::CFG_NL_TO_CR:     prdata[0] = newline_to_return;
      slu_pkg::CFG_ALIAS_ENABLE: prdata[0] = alias_enable;
      default:                   prdata    = '0;
    endcase
  end

  // result register frees when empty or being taken
  assign advance   = !rsp_valid || !rsp_stall;
  assign cmd_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      s1_cmd <= cmd;
    end
  end

  // when alias is enabled, the alias range folds onto the primary range
  always_comb begin
    addr = s1_cmd.address;
    if (alias_enable && ((s1_cmd.address & slu_pkg::RANGE_MASK) == slu_pkg::ALIAS_BASE)) begin
      addr = slu_pkg::PRIMARY_BASE | {13'd0, s1_cmd.address[2:0]};
    end
  end

  assign host_c = (newline_to_return && s1_cmd.host_char == slu_pkg::CHAR_LF) ?
                  slu_pkg::CHAR_CR : s1_cmd.host_char;

  always_comb begin
    rx_byte_next          = rx_byte;
    rx_done_next          = rx_done;
    rx_enable_next        = rx_enable;
    rx_request_next       = rx_request;
    tx_done_next          = tx_done;
    tx_enable_next        = tx_enable;
    tx_request_next       = tx_request;
    maint_break_bits_next = maint_break_bits;
    rsp_next              = '0;

    unique case (s1_cmd.mode)
      slu_pkg::MODE_READ: begin
        unique case (addr)
          slu_pkg::ADDR_RCSR: begin
            rsp_next.read_data[slu_pkg::DONE_POS] = rx_done;
            rsp_next.read_data[slu_pkg::IE_POS]   = rx_enable;
          end
          slu_pkg::ADDR_RBUF: begin
            rsp_next.read_data = rx_byte;
            rx_done_next       = 1'b0;
            rx_request_next    = 1'b0;
          end
          slu_pkg::ADDR_TCSR: begin
            rsp_next.read_data[slu_pkg::DONE_POS]  = tx_done;
            rsp_next.read_data[slu_pkg::IE_POS]    = tx_enable;
            rsp_next.read_data[slu_pkg::MAINT_POS] = maint_break_bits[1];
            rsp_next.read_data[slu_pkg::BREAK_POS] = maint_break_bits[0];
          end
          default: ;
        endcase
      end
      slu_pkg::MODE_WRITE: begin
        unique case (addr)
          slu_pkg::ADDR_RCSR: begin
            if (s1_cmd.write_data[slu_pkg::IE_POS]) begin
              if (!rx_enable && rx_done) rx_request_next = 1'b1;
              rx_enable_next = 1'b1;
            end else begin
              rx_enable_next = 1'b0;
            end
            if (s1_cmd.write_data[slu_pkg::RE_POS]) begin
              rx_done_next    = 1'b0;
              rx_request_next = 1'b0;
            end
          end
          slu_pkg::ADDR_RBUF: begin
            rx_done_next    = 1'b0;
            rx_request_next = 1'b0;
          end
          slu_pkg::ADDR_TCSR: begin
            maint_break_bits_next = {s1_cmd.write_data[slu_pkg::MAINT_POS],
                                     s1_cmd.write_data[slu_pkg::BREAK_POS]};
            if (s1_cmd.write_data[slu_pkg::IE_POS]) begin
              if (!tx_enable && tx_done) tx_request_next = 1'b1;
              tx_enable_next = 1'b1;
            end else begin
              tx_enable_next = 1'b0;
            end
          end
          slu_pkg::ADDR_TBUF: begin
            // done drops and rises again in the same beat
            tx_done_next     = 1'b1;
            tx_request_next  = tx_enable;
            rsp_next.tx_valid = 1'b1;
            rsp_next.tx_char  = slu_pkg::mask_char(s1_cmd.write_data, eight_bit_mode);
          end
          default: ;
        endcase
      end
      slu_pkg::MODE_HOST_CHAR: begin
        if (!rx_done && s1_cmd.host_char != slu_pkg::CHAR_NUL) begin
          rx_byte_next      = slu_pkg::mask_char(host_c, eight_bit_mode);
          rx_done_next      = 1'b1;
          if (rx_enable) rx_request_next = 1'b1;
          rsp_next.rx_taken = 1'b1;
        end
      end
      slu_pkg::MODE_RX_ACK: rx_request_next = 1'b0;
      slu_pkg::MODE_TX_ACK: tx_request_next = 1'b0;
      default: ;
    endcase

    rsp_next.rx_irq = rx_request_next;
    rsp_next.tx_irq = tx_request_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_byte          <= '0;
      rx_done          <= 1'b0;
      rx_enable        <= 1'b0;
      rx_request       <= 1'b0;
      tx_done          <= 1'b1;
      tx_enable        <= 1'b0;
      tx_request       <= 1'b0;
      maint_break_bits <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (fire) begin
        rx_byte          <= rx_byte_next;
        rx_done          <= rx_done_next;
        rx_enable        <= rx_enable_next;
        rx_request       <= rx_request_next;
        tx_done          <= tx_done_next;
        tx_enable        <= tx_enable_next;
        tx_request       <= tx_request_next;
        maint_break_bits <= maint_break_bits_next;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // a delivered character always sits in the receive latch until something clears it
  a_rx_taken_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rx_taken |-> rx_done)
    else $error("rx_taken shown without receiver done");

  // the interrupt lines in the result track the latches they were taken from
  a_irq_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.rx_irq == rx_request) && (rsp.tx_irq == tx_request))
    else $error("result interrupt lines disagree with latches");

  a_tx_req_en: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.tx_valid |-> rsp.tx_irq == tx_enable)
    else $error("transmit request not set from enable on send");

  // transmit completes in the same beat, so done never stays low
  a_tx_done: assert property (@(posedge clk) disable iff (rst) tx_done)
    else $error("transmitter done dropped");

endmodule
